### rtl/ualoha_pkg.sv
// Shared types and constants for the unslotted ALOHA access controller.
package ualoha_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_REQ   = 2'd1;
  localparam logic [1:0] FUNC_HEARD = 2'd2;

  // Configuration register indexes (byte address 4 * index)
  localparam logic [1:0] REG_OWN_ADDR     = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT  = 2'd1;
  localparam logic [1:0] REG_SEND_TIMEOUT = 2'd2;

  // Fixed field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned LIMIT_W  = 4;
  localparam int unsigned RETRY_W  = 5;
  localparam int unsigned TXLEN_W  = 16;
  localparam int unsigned CFG_AW   = 4;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST = 4'd3;

  // Status of one step, handed from the core to the result register
  typedef struct packed {
    logic               start_tx;
    logic               deliver_up;
    logic               tx_complete;
    logic               tx_abandoned;
    logic               collision_for_us;
    logic               tx_idle;
    logic [RETRY_W-1:0] retry_count;
  } step_flags_t;

endpackage

### rtl/ualoha_cfg_regs.sv
// APB-style configuration registers of the ALOHA access controller.
module ualoha_cfg_regs #(
  parameter int unsigned ADDR_BITS = 8,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ualoha_pkg::CFG_AW-1:0]       paddr,
  input  logic [ualoha_pkg::CFG_DW-1:0]       pwdata,
  output logic [ualoha_pkg::CFG_DW-1:0]       prdata,
  output logic                                pready,
  output logic [ADDR_BITS-1:0]                own_addr,
  output logic [ualoha_pkg::LIMIT_W-1:0]      retry_limit,
  output logic [TIME_BITS-1:0]                send_timeout
);

  logic [ADDR_BITS-1:0]           own_addr_r, own_addr_nxt;
  logic [ualoha_pkg::LIMIT_W-1:0] retry_limit_r, retry_limit_nxt;
  logic [TIME_BITS-1:0]           send_timeout_r, send_timeout_nxt;
  logic [1:0]                     reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Decode the write transfer
  always_comb begin
    own_addr_nxt     = own_addr_r;
    retry_limit_nxt  = retry_limit_r;
    send_timeout_nxt = send_timeout_r;
    if (wr_en) begin
      case (reg_idx)
        ualoha_pkg::REG_OWN_ADDR:     own_addr_nxt     = pwdata[ADDR_BITS-1:0];
        ualoha_pkg::REG_RETRY_LIMIT:  retry_limit_nxt  = pwdata[ualoha_pkg::LIMIT_W-1:0];
        ualoha_pkg::REG_SEND_TIMEOUT: send_timeout_nxt = pwdata[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r     <= '0;
      retry_limit_r  <= ualoha_pkg::RETRY_LIMIT_RST;
      send_timeout_r <= TIME_BITS'(100);
    end else begin
      own_addr_r     <= own_addr_nxt;
      retry_limit_r  <= retry_limit_nxt;
      send_timeout_r <= send_timeout_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      ualoha_pkg::REG_OWN_ADDR:     prdata = ualoha_pkg::CFG_DW'(own_addr_r);
      ualoha_pkg::REG_RETRY_LIMIT:  prdata = ualoha_pkg::CFG_DW'(retry_limit_r);
      ualoha_pkg::REG_SEND_TIMEOUT: prdata = ualoha_pkg::CFG_DW'(send_timeout_r);
      default:                      prdata = '0;
    endcase
  end

  assign own_addr     = own_addr_r;
  assign retry_limit  = retry_limit_r;
  assign send_timeout = send_timeout_r;

endmodule

### rtl/ualoha_core.sv
// Transmit and receive state of the ALOHA controller with its one-step update.
module ualoha_core #(
  parameter int unsigned ADDR_BITS = 8,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic [ualoha_pkg::FUNC_W-1:0]      func,
  input  logic [TIME_BITS-1:0]               frame_len,
  input  logic [ADDR_BITS-1:0]               frame_dst,
  input  logic [ADDR_BITS-1:0]               frame_src,
  input  logic [TIME_BITS-1:0]               backoff_draw,
  input  logic [ADDR_BITS-1:0]               own_addr,
  input  logic [ualoha_pkg::LIMIT_W-1:0]     retry_limit,
  input  logic [TIME_BITS-1:0]               send_timeout,
  output ualoha_pkg::step_flags_t            flags,
  output logic [ualoha_pkg::TXLEN_W-1:0]     tx_len,
  output logic [ADDR_BITS-1:0]               deliver_src
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_SEND = 2'd1;
  localparam logic [1:0] M_BACK = 2'd2;

  localparam int unsigned SC_W = TIME_BITS + 1;

  logic [1:0]                     mode_r, mode_nxt;
  logic                           rx_busy_r, rx_busy_nxt;
  logic [ualoha_pkg::RETRY_W-1:0] retries_r, retries_nxt;
  logic [SC_W-1:0]                send_cnt_r, send_cnt_nxt;
  logic [TIME_BITS-1:0]           recv_cnt_r, recv_cnt_nxt;
  logic                           pend_vld_r, pend_vld_nxt;
  logic [ADDR_BITS-1:0]           pend_dst_r, pend_dst_nxt;
  logic [ADDR_BITS-1:0]           pend_src_r, pend_src_nxt;
  logic [TIME_BITS-1:0]           saved_len_r, saved_len_nxt;

  logic [TIME_BITS-1:0]           recv_dec;
  logic [SC_W-1:0]                send_dec;
  logic [ualoha_pkg::RETRY_W-1:0] retries_inc;
  logic [TIME_BITS-1:0]           send_len;
  logic [SC_W-1:0]                send_load;
  logic                           freed;
  logic                           pend_for_us;
  logic                           frame_for_us;

  assign recv_dec     = (recv_cnt_r != '0) ? recv_cnt_r - 1'b1 : '0;
  assign send_dec     = (send_cnt_r != '0) ? send_cnt_r - 1'b1 : '0;
  assign retries_inc  = retries_r + 1'b1;
  assign pend_for_us  = (pend_dst_r == '1) || (pend_dst_r == own_addr);
  assign frame_for_us = (frame_dst == '1) || (frame_dst == own_addr);

  // Frame length for a send: a fresh request or the stored frame on retry
  assign send_len  = (func == ualoha_pkg::FUNC_REQ) ? frame_len : saved_len_r;
  assign send_load = {1'b0, send_timeout} + {1'b0, send_len};

  // Next state and status for one item
  always_comb begin
    mode_nxt      = mode_r;
    rx_busy_nxt   = rx_busy_r;
    retries_nxt   = retries_r;
    send_cnt_nxt  = send_cnt_r;
    recv_cnt_nxt  = recv_cnt_r;
    pend_vld_nxt  = pend_vld_r;
    pend_dst_nxt  = pend_dst_r;
    pend_src_nxt  = pend_src_r;
    saved_len_nxt = saved_len_r;
    freed         = 1'b0;
    flags         = '0;
    tx_len        = '0;
    deliver_src   = '0;

    case (func)
      ualoha_pkg::FUNC_TICK: begin
        // Receive side first: close the contention period when it runs out
        if (rx_busy_r) begin
          recv_cnt_nxt = recv_dec;
          if (recv_dec == '0) begin
            rx_busy_nxt = 1'b0;
            if (pend_vld_r) begin
              pend_vld_nxt = 1'b0;
              if (pend_src_r == own_addr) begin
                mode_nxt          = M_IDLE;
                retries_nxt       = '0;
                send_cnt_nxt      = '0;
                flags.tx_complete = 1'b1;
                freed             = 1'b1;
              end else if (pend_for_us) begin
                flags.deliver_up = 1'b1;
                deliver_src      = pend_src_r;
              end
            end
          end
        end
        // Send timer, unless the echo just freed the transmitter
        if (!freed && mode_r != M_IDLE) begin
          send_cnt_nxt = send_dec;
          if (send_dec == '0) begin
            if (mode_r == M_SEND) begin
              if (retries_inc <= ualoha_pkg::RETRY_W'(retry_limit)) begin
                mode_nxt     = M_BACK;
                retries_nxt  = retries_inc;
                send_cnt_nxt = SC_W'(backoff_draw);
              end else begin
                mode_nxt           = M_IDLE;
                retries_nxt        = '0;
                flags.tx_abandoned = 1'b1;
              end
            end else begin
              mode_nxt       = M_SEND;
              send_cnt_nxt   = send_load;
              flags.start_tx = 1'b1;
              tx_len         = ualoha_pkg::TXLEN_W'(saved_len_r);
            end
          end
        end
      end
      ualoha_pkg::FUNC_REQ: begin
        // Take a request only when the transmitter is free
        if (mode_r == M_IDLE) begin
          saved_len_nxt  = frame_len;
          mode_nxt       = M_SEND;
          send_cnt_nxt   = send_load;
          flags.start_tx = 1'b1;
          tx_len         = ualoha_pkg::TXLEN_W'(frame_len);
        end
      end
      ualoha_pkg::FUNC_HEARD: begin
        if (!rx_busy_r) begin
          rx_busy_nxt  = 1'b1;
          pend_vld_nxt = 1'b1;
          pend_dst_nxt = frame_dst;
          pend_src_nxt = frame_src;
          recv_cnt_nxt = frame_len;
        end else begin
          // Overlap: drop both frames and stretch to the longer end
          if (frame_len > recv_cnt_r) recv_cnt_nxt = frame_len;
          pend_vld_nxt           = 1'b0;
          flags.collision_for_us = (pend_vld_r && pend_for_us) || frame_for_us;
        end
      end
      default: ;
    endcase

    flags.tx_idle     = (mode_nxt == M_IDLE);
    flags.retry_count = retries_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      rx_busy_r  <= 1'b0;
      retries_r  <= '0;
      send_cnt_r <= '0;
      recv_cnt_r <= '0;
      pend_vld_r <= 1'b0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      rx_busy_r  <= rx_busy_nxt;
      retries_r  <= retries_nxt;
      send_cnt_r <= send_cnt_nxt;
      recv_cnt_r <= recv_cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // Frame details only matter while marked valid or while the transmitter is busy
  always_ff @(posedge clk) begin
    if (step) begin
      pend_dst_r  <= pend_dst_nxt;
      pend_src_r  <= pend_src_nxt;
      saved_len_r <= saved_len_nxt;
    end
  end

endmodule

### rtl/unslotted_aloha_mac.sv
// Top level of the unslotted ALOHA access controller: input stage, core and result stage.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in_     | slave     | tvalid/tready      | tuser: func; tdata: len, dst, src, draw
//  out_    | master    | tvalid/tready      | tdata: status of one step (see port)
//  cfg_    | slave     | APB psel/penable   | own_addr @0, retry_limit @4, send_timeout @8
//
// One item per cycle sustained while the result is not stalled; an input transfer goes
// through the input register, then a single-pass core update into the result register.
// rst_n is synchronous, active low, and clears both stage valids and the MAC state.
// A stalled result holds the result register; the input register keeps taking an
// item while it is empty, or while the result register is empty or drains in the same cycle.
module unslotted_aloha_mac #(
  parameter int unsigned ADDR_BITS = 8,
  parameter int unsigned TIME_BITS = 16,
  localparam int unsigned IN_BITS  = 2 * TIME_BITS + 2 * ADDR_BITS,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = 27 + ADDR_BITS,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // frame_len, frame_dst, frame_src, backoff_draw, zero pad
  input  logic [IN_W-1:0]                   in_tdata,
  // func
  input  logic [ualoha_pkg::FUNC_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // start_tx, tx_len, deliver_up, deliver_src, tx_complete, tx_abandoned,
  // collision_for_us, tx_idle, retry_count, zero pad
  output logic [OUT_W-1:0]                  out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ualoha_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [ualoha_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [ualoha_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                              cfg_pready
);

  logic                           s1_vld_r, s1_vld_nxt;
  logic [ualoha_pkg::FUNC_W-1:0]  s1_func_r;
  logic [IN_BITS-1:0]             s1_data_r;
  logic                           out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0]               out_data_r;
  logic                           in_xfer;
  logic                           s1_go;

  logic [ADDR_BITS-1:0]           own_addr;
  logic [ualoha_pkg::LIMIT_W-1:0] retry_limit;
  logic [TIME_BITS-1:0]           send_timeout;

  ualoha_pkg::step_flags_t        flags;
  logic [ualoha_pkg::TXLEN_W-1:0] tx_len;
  logic [ADDR_BITS-1:0]           deliver_src;
  logic [OUT_BITS-1:0]            result;

  ualoha_cfg_regs #(
    .ADDR_BITS (ADDR_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .own_addr     (own_addr),
    .retry_limit  (retry_limit),
    .send_timeout (send_timeout)
  );

  // Stage handshake: advance when the result register is free or draining
  assign s1_go     = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_go;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) s1_vld_nxt = 1'b1;
    else if (s1_go) s1_vld_nxt = 1'b0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_go) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r <= in_tuser;
      s1_data_r <= in_tdata[IN_BITS-1:0];
    end
  end

  ualoha_core #(
    .ADDR_BITS (ADDR_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_go),
    .func         (s1_func_r),
    .frame_len    (s1_data_r[TIME_BITS-1:0]),
    .frame_dst    (s1_data_r[TIME_BITS +: ADDR_BITS]),
    .frame_src    (s1_data_r[TIME_BITS+ADDR_BITS +: ADDR_BITS]),
    .backoff_draw (s1_data_r[TIME_BITS+2*ADDR_BITS +: TIME_BITS]),
    .own_addr     (own_addr),
    .retry_limit  (retry_limit),
    .send_timeout (send_timeout),
    .flags        (flags),
    .tx_len       (tx_len),
    .deliver_src  (deliver_src)
  );

  // Pack the step status, first field lowest
  assign result = {flags.retry_count, flags.tx_idle, flags.collision_for_us,
                   flags.tx_abandoned, flags.tx_complete, deliver_src,
                   flags.deliver_up, tx_len, flags.start_tx};

  always_ff @(posedge clk) begin
    if (s1_go) out_data_r <= OUT_W'(result);
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/ualoha_checker.sv
// Port-level checks of the ALOHA access controller, bound to the top level.
module ualoha_checker #(
  parameter int unsigned ADDR_BITS = 8,
  parameter int unsigned TIME_BITS = 16,
  localparam int unsigned OUT_BITS = 27 + ADDR_BITS,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8,
  localparam int unsigned B_CMPL   = 18 + ADDR_BITS,
  localparam int unsigned B_ABND   = 19 + ADDR_BITS,
  localparam int unsigned B_IDLE   = 21 + ADDR_BITS,
  localparam int unsigned B_RETRY  = 22 + ADDR_BITS
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic start_tx, tx_complete, tx_abandoned, tx_idle;
  logic [ualoha_pkg::RETRY_W-1:0] retry_count;

  assign start_tx     = out_tdata[0];
  assign tx_complete  = out_tdata[B_CMPL];
  assign tx_abandoned = out_tdata[B_ABND];
  assign tx_idle      = out_tdata[B_IDLE];
  assign retry_count  = out_tdata[B_RETRY +: ualoha_pkg::RETRY_W];

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A send leaves the transmitter busy and cannot coincide with an echo
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && start_tx |-> !tx_idle && !tx_complete)
    else $error("start_tx with idle transmitter or completion");

  // Giving up a frame frees the transmitter and clears the retries
  a_abandon_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && tx_abandoned |-> tx_idle && retry_count == '0 && !start_tx)
    else $error("abandon left transmitter busy");

endmodule

bind unslotted_aloha_mac ualoha_checker #(
  .ADDR_BITS (ADDR_BITS),
  .TIME_BITS (TIME_BITS)
) u_ualoha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### bench/testbench.sv
// Self-checking bench for the unslotted ALOHA access controller: stream traffic, APB setup.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [7:0] BROADCAST = 8'hFF;

  typedef enum logic [1:0] {
    TX_IDLE    = 2'd0,
    TX_SENDING = 2'd1,
    TX_BACKOFF = 2'd2
  } tx_mode_t;

  // Input tdata layout, lowest field last
  typedef struct packed {
    logic [15:0] draw;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] len;
  } frame_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    frame_word_t word;
  } mac_item_t;

  // Result tdata layout, lowest field last
  typedef struct packed {
    logic [4:0]  pad;
    logic [4:0]  retry_count;
    logic        tx_idle;
    logic        collision_for_us;
    logic        tx_abandoned;
    logic        tx_complete;
    logic [7:0]  deliver_src;
    logic        deliver_up;
    logic [15:0] tx_len;
    logic        start_tx;
  } mac_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  unslotted_aloha_mac u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Station settings as the bench believes them
  logic [7:0]  own_station = 8'd0;
  logic [3:0]  retry_max = 4'd3;
  logic [15:0] echo_timeout = 16'd100;

  // Predicted controller state
  tx_mode_t    mac_mode = TX_IDLE;
  logic        rx_active = 1'b0;
  logic        rx_pending = 1'b0;
  logic [4:0]  retry_cnt = '0;
  logic [16:0] tx_ticks_left = '0;
  logic [15:0] rx_ticks_left = '0;
  logic [7:0]  rx_dst = '0;
  logic [7:0]  rx_src = '0;
  logic [15:0] held_len = '0;

  mac_item_t   frames_to_send[$];
  mac_status_t status_due[$];
  mac_item_t   offered_item;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_count = 0;
  int unsigned cycle_count = 0;
  int unsigned status_errors = 0;
  int unsigned reg_errors = 0;

  function automatic bit addressed_here(input logic [7:0] dst);
    return dst == BROADCAST || dst == own_station;
  endfunction

  // Load the send timer and put the frame on the channel
  function automatic void launch_frame(input logic [15:0] len, inout mac_status_t st);
    mac_mode = TX_SENDING;
    tx_ticks_left = {1'b0, echo_timeout} + {1'b0, len};
    st.start_tx = 1'b1;
    st.tx_len = len;
  endfunction

  // Advance the predicted controller by one item and return its status
  function automatic mac_status_t mac_advance(input mac_item_t item);
    mac_status_t st;
    bit freed;
    bit hit;
    st = '0;
    freed = 1'b0;
    hit = 1'b0;
    case (item.kind)
      ualoha_pkg::FUNC_TICK: begin
        // Receive side acts first
        if (rx_active) begin
          if (rx_ticks_left != 0) rx_ticks_left = rx_ticks_left - 16'd1;
          if (rx_ticks_left == 0) begin
            rx_active = 1'b0;
            if (rx_pending) begin
              rx_pending = 1'b0;
              if (rx_src == own_station) begin
                mac_mode = TX_IDLE;
                retry_cnt = '0;
                tx_ticks_left = '0;
                st.tx_complete = 1'b1;
                freed = 1'b1;
              end else if (addressed_here(rx_dst)) begin
                st.deliver_up = 1'b1;
                st.deliver_src = rx_src;
              end
            end
          end
        end
        if (!freed && mac_mode != TX_IDLE) begin
          if (tx_ticks_left != 0) tx_ticks_left = tx_ticks_left - 17'd1;
          if (tx_ticks_left == 0) begin
            if (mac_mode == TX_SENDING) begin
              retry_cnt = retry_cnt + 5'd1;
              if (retry_cnt <= {1'b0, retry_max}) begin
                mac_mode = TX_BACKOFF;
                tx_ticks_left = {1'b0, item.word.draw};
              end else begin
                mac_mode = TX_IDLE;
                retry_cnt = '0;
                st.tx_abandoned = 1'b1;
              end
            end else begin
              launch_frame(held_len, st);
            end
          end
        end
      end
      ualoha_pkg::FUNC_REQ: begin
        if (mac_mode == TX_IDLE) begin
          held_len = item.word.len;
          launch_frame(item.word.len, st);
        end
      end
      ualoha_pkg::FUNC_HEARD: begin
        if (!rx_active) begin
          rx_active = 1'b1;
          rx_pending = 1'b1;
          rx_dst = item.word.dst;
          rx_src = item.word.src;
          rx_ticks_left = item.word.len;
        end else begin
          // Overlap: stretch contention, drop both frames
          if (item.word.len > rx_ticks_left) rx_ticks_left = item.word.len;
          if (rx_pending && addressed_here(rx_dst)) hit = 1'b1;
          if (addressed_here(item.word.dst)) hit = 1'b1;
          rx_pending = 1'b0;
          st.collision_for_us = hit;
        end
      end
      default: ;
    endcase
    st.tx_idle = (mac_mode == TX_IDLE);
    st.retry_count = retry_cnt;
    return st;
  endfunction

  function automatic int unsigned field_diff(input string what, input longint unsigned want,
                                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Driver: record the accepted transfer, then offer the next item
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      status_due.push_back(mac_advance(offered_item));
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered_item = frames_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= offered_item.word;
        in_tuser <= offered_item.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    mac_status_t want;
    mac_status_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
        status_errors <= status_errors + 1;
      end else begin
        want = status_due.pop_front();
        status_errors <= status_errors
          + field_diff("start_tx", want.start_tx, got.start_tx)
          + field_diff("tx_len", want.tx_len, got.tx_len)
          + field_diff("deliver_up", want.deliver_up, got.deliver_up)
          + field_diff("deliver_src", want.deliver_src, got.deliver_src)
          + field_diff("tx_complete", want.tx_complete, got.tx_complete)
          + field_diff("tx_abandoned", want.tx_abandoned, got.tx_abandoned)
          + field_diff("collision_for_us", want.collision_for_us, got.collision_for_us)
          + field_diff("tx_idle", want.tx_idle, got.tx_idle)
          + field_diff("retry_count", want.retry_count, got.retry_count);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_frame(input logic [1:0] kind, input logic [15:0] len,
                             input logic [7:0] dst, input logic [7:0] src,
                             input logic [15:0] draw);
    mac_item_t item;
    item.kind = kind;
    item.word.len = len;
    item.word.dst = dst;
    item.word.src = src;
    item.word.draw = draw;
    frames_to_send.push_back(item);
  endtask

  task automatic queue_ticks(input int unsigned count);
    logic [15:0] draw;
    repeat (count) begin
      draw = ($urandom_range(49) == 0) ? 16'($urandom) : 16'($urandom_range(4));
      queue_frame(ualoha_pkg::FUNC_TICK, 16'($urandom), 8'($urandom), 8'($urandom), draw);
    end
  endtask

  function automatic logic [7:0] pick_dst();
    int unsigned roll;
    roll = $urandom_range(11);
    if (roll < 4) return own_station;
    if (roll < 7) return BROADCAST;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_peer();
    logic [7:0] peer;
    peer = 8'($urandom);
    if (peer == own_station) peer = peer ^ 8'h01;
    return peer;
  endfunction

  // Mostly well-formed exchanges with random content, some noise
  task automatic queue_traffic(input int unsigned count);
    int unsigned made;
    int unsigned pick;
    int unsigned len;
    int unsigned len2;
    int unsigned gap;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      len = ($urandom_range(19) == 0) ? $urandom_range(60, 1) : $urandom_range(6, 1);
      len2 = $urandom_range(8, 1);
      gap = $urandom_range(len + 2);
      if (pick < 30) begin
        // own frame sent and heard back
        queue_frame(ualoha_pkg::FUNC_REQ, 16'(len), 8'($urandom), 8'($urandom),
                    16'($urandom));
        queue_ticks(gap);
        queue_frame(ualoha_pkg::FUNC_HEARD, 16'(len), pick_dst(), own_station,
                    16'($urandom));
        queue_ticks(len + 1);
        made += gap + len + 3;
      end else if (pick < 55) begin
        // frame from a peer
        queue_frame(ualoha_pkg::FUNC_HEARD, 16'(len), pick_dst(), pick_peer(),
                    16'($urandom));
        queue_ticks(len + 1);
        made += len + 2;
      end else if (pick < 70) begin
        // two overlapping frames
        queue_frame(ualoha_pkg::FUNC_HEARD, 16'(len), pick_dst(), pick_peer(),
                    16'($urandom));
        queue_ticks(gap % len);
        queue_frame(ualoha_pkg::FUNC_HEARD, 16'(len2), pick_dst(),
                    ($urandom_range(3) == 0) ? own_station : pick_peer(), 16'($urandom));
        queue_ticks(len + len2 + 1);
        made += gap % len + len + len2 + 3;
      end else if (pick < 85) begin
        // send with no echo: time out, back off, retry
        gap = $urandom_range(40, 5);
        queue_frame(ualoha_pkg::FUNC_REQ, 16'(len), 8'($urandom), 8'($urandom),
                    16'($urandom));
        queue_ticks(gap);
        made += gap + 1;
      end else begin
        // noise over the whole field ranges
        repeat ($urandom_range(4, 1)) begin
          pick = $urandom_range(3);
          if (pick == ualoha_pkg::FUNC_HEARD)
            len = ($urandom_range(9) == 0) ? $urandom_range(300, 1) : $urandom_range(8, 1);
          else
            len = $urandom_range(65535, 1);
          queue_frame(2'(pick), 16'(len), 8'($urandom), 8'($urandom),
                      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8)));
          if (pick != FUNC_UNUSED) made++;
        end
      end
    end
  endtask

  // APB write, then read back through the same selection
  task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      ualoha_pkg::REG_OWN_ADDR:     own_station = value[7:0];
      ualoha_pkg::REG_RETRY_LIMIT:  retry_max = value[3:0];
      ualoha_pkg::REG_SEND_TIMEOUT: echo_timeout = value[15:0];
      default: ;
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== value) begin
      $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
               $time, idx, value, cfg_prdata);
      reg_errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic setup_station(input logic [7:0] addr, input logic [3:0] limit,
                               input logic [15:0] timeout);
    program_reg(ualoha_pkg::REG_OWN_ADDR, {24'd0, addr});
    program_reg(ualoha_pkg::REG_RETRY_LIMIT, {28'd0, limit});
    program_reg(ualoha_pkg::REG_SEND_TIMEOUT, {16'd0, timeout});
    @(negedge clk);
  endtask

  // Hold until every result is back and the pipeline has settled
  task automatic drain();
    while (frames_to_send.size() != 0 || status_due.size() != 0 || in_tvalid)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every item kind, field extremes, corner cases
    send_idle_pct = 7;
    recv_idle_pct = 59;
    setup_station(8'h5A, 4'd1, 16'd2);
    queue_frame(ualoha_pkg::FUNC_TICK, 16'd1, 8'h00, 8'h00, 16'h0000);
    queue_frame(FUNC_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
    queue_frame(ualoha_pkg::FUNC_REQ, 16'd3, 8'h00, 8'h00, 16'h0000);
    // request while busy is dropped
    queue_frame(ualoha_pkg::FUNC_REQ, 16'd9, 8'h00, 8'h00, 16'h0000);
    // own echo frees the transmitter on the same tick the timer runs
    queue_frame(ualoha_pkg::FUNC_HEARD, 16'd2, 8'h11, 8'h5A, 16'h0000);
    queue_ticks(2);
    // broadcast delivered upward
    queue_frame(ualoha_pkg::FUNC_HEARD, 16'd1, BROADCAST, 8'h22, 16'h0000);
    queue_ticks(1);
    // collision, first frame addressed here
    queue_frame(ualoha_pkg::FUNC_HEARD, 16'd3, 8'h5A, 8'h23, 16'h0000);
    queue_frame(ualoha_pkg::FUNC_HEARD, 16'd2, 8'h01, 8'h24, 16'h0000);
    queue_ticks(3);
    // frame for another station dropped
    queue_frame(ualoha_pkg::FUNC_HEARD, 16'd1, 8'h00, 8'hFF, 16'h0000);
    queue_ticks(1);
    // timeout, zero backoff, retransmit, then abandon
    queue_frame(ualoha_pkg::FUNC_REQ, 16'd1, 8'h00, 8'h00, 16'h0000);
    queue_frame(ualoha_pkg::FUNC_TICK, 16'd1, 8'h00, 8'h00, 16'h0000);
    queue_frame(ualoha_pkg::FUNC_TICK, 16'd1, 8'h00, 8'h00, 16'h0000);
    queue_frame(ualoha_pkg::FUNC_TICK, 16'd1, 8'h00, 8'h00, 16'h0000);
    queue_frame(ualoha_pkg::FUNC_TICK, 16'd1, 8'h00, 8'h00, 16'hFFFF);
    queue_ticks(3);
    // stray own echo while idle
    queue_frame(ualoha_pkg::FUNC_HEARD, 16'd1, 8'h77, 8'h5A, 16'h0000);
    queue_ticks(1);
    drain();

    queue_traffic(450);
    drain();

    setup_station(8'd0, 4'd0, 16'd0);
    queue_traffic(350);
    drain();

    send_idle_pct = 59;
    recv_idle_pct = 7;
    setup_station(8'd254, 4'd15, 16'd3);
    queue_traffic(350);
    drain();

    // own address all ones also answers broadcast
    setup_station(8'hFF, 4'd2, 16'd1);
    queue_traffic(200);
    drain();

    // No idling; receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    setup_station(8'h33, 4'd7, 16'hFFFF);
    queue_traffic(400);
    hold_req = 1'b1;
    while (!hold_done) @(negedge clk);
    drain();

    if (status_errors == 0 && reg_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ualoha_pkg.sv
rtl/ualoha_cfg_regs.sv
rtl/ualoha_core.sv
rtl/unslotted_aloha_mac.sv
rtl/ualoha_checker.sv
bench/testbench.sv
